### hw/rtl/sorted_keyed_list_unit_assert.svh
// ---------------------------------------------------------------------------
// sorted keyed list assertion macros
// shared concurrent assertion forms for the sorted keyed list unit
// ---------------------------------------------------------------------------
`ifndef SORTED_KEYED_LIST_UNIT_ASSERT_SVH
`define SORTED_KEYED_LIST_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SKL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/skl_pkg.sv
// ---------------------------------------------------------------------------
// skl_pkg
// action and status codes and the broadcast bundle of the sorted keyed list
// ---------------------------------------------------------------------------
package skl_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT       = 3'd0,
        ACT_REMOVE_KEY   = 3'd1,
        ACT_REMOVE_FIRST = 3'd2,
        ACT_REMOVE_LAST  = 3'd3,
        ACT_READ         = 3'd4,
        ACT_FIND         = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int POS_W = 5;

    // request fields broadcast to every cell
    typedef struct packed {
        act_t                    act;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic                    go;
    } bcast_t;

endpackage

### hw/rtl/skl_cell.sv
// ---------------------------------------------------------------------------
// skl_cell
// one list slot: holds a key and payload, shifts with its neighbors
// ---------------------------------------------------------------------------
module skl_cell (
    input  logic                            clk,
    input  skl_pkg::bcast_t                 bc,
    input  logic                            valid,
    input  logic                            found,
    input  logic                            left_ge,
    input  logic signed [skl_pkg::KEY_W-1:0] left_key,
    input  logic [skl_pkg::PAY_W-1:0]        left_pay,
    input  logic signed [skl_pkg::KEY_W-1:0] right_key,
    input  logic [skl_pkg::PAY_W-1:0]        right_pay,
    output logic                            ge,
    output logic                            match,
    output logic signed [skl_pkg::KEY_W-1:0] key,
    output logic [skl_pkg::PAY_W-1:0]        pay
);
    import skl_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0]        pay_reg, pay_next;

    // empty slots count as greater so the flag stays a thermometer
    assign ge    = !valid || !(key_reg < bc.key);
    assign match = valid && (key_reg == bc.key);
    assign key   = key_reg;
    assign pay   = pay_reg;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (bc.go)
        begin
            case (bc.act)
                ACT_INSERT:
                begin
                    if (ge && !left_ge)
                    begin
                        key_next = bc.key;
                        pay_next = bc.payload;
                    end
                    else if (left_ge)
                    begin
                        key_next = left_key;
                        pay_next = left_pay;
                    end
                end
                ACT_REMOVE_KEY:
                begin
                    if (found && ge)
                    begin
                        key_next = right_key;
                        pay_next = right_pay;
                    end
                end
                ACT_REMOVE_FIRST:
                begin
                    key_next = right_key;
                    pay_next = right_pay;
                end
                default:
                begin
                    key_next = key_reg;
                    pay_next = pay_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

endmodule

### hw/rtl/sorted_keyed_list_unit.sv
// the result beat of an accepted request is registered and appears in the next cycle
// throughput: one request per cycle, all slots compare and shift together
// the input stalls only while a result waits and is not taken in the same cycle
// reset: entry count and output valid clear at once; slot contents stay
// undefined and are never read before an insert writes them
// ---------------------------------------------------------------------------
// sorted_keyed_list_unit
// bounded list of key/payload entries kept in ascending signed key order,
// built as a row of slot cells that all shift left or right in the same cycle
// ---------------------------------------------------------------------------
`include "sorted_keyed_list_unit_assert.svh"

module sorted_keyed_list_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_key[31:0], entry_payload[63:32], position[68:64]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // found_key[31:0], found_payload[63:32], entry_count[68:64]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import skl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + POS_W;

    // count of held entries; slot i is live when i < count
    logic [CW-1:0] count_reg, count_next;

    // result register
    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    logic s_acc;
    act_t act;
    logic signed [KEY_W-1:0] req_key;
    logic [PAY_W-1:0]        req_pay;
    logic [POS_W-1:0]        req_pos;
    logic [XW-1:0]           pos_ext, count_ext, count_next_ext;
    logic full, empty;

    // per-slot chain signals
    logic                    valid [CAPACITY];
    logic                    ge    [CAPACITY];
    logic                    match [CAPACITY];
    logic                    sel   [CAPACITY];
    logic [CAPACITY-1:0]     sel_vec;
    logic signed [KEY_W-1:0] slot_key [CAPACITY];
    logic [PAY_W-1:0]        slot_pay [CAPACITY];

    logic found, hit, go;
    status_t status_next;
    logic signed [KEY_W-1:0] res_key;
    logic [PAY_W-1:0]        res_pay;
    bcast_t bc;

    // a new beat is taken whenever the result register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign act     = act_t'(s_tuser);
    assign req_key = s_tdata[31:0];
    assign req_pay = s_tdata[63:32];
    assign req_pos = s_tdata[68:64];

    assign pos_ext        = {{CW{1'b0}}, req_pos};
    assign count_ext      = {{POS_W{1'b0}}, count_reg};
    assign count_next_ext = {{POS_W{1'b0}}, count_next};
    assign full           = (count_reg == CW'(CAPACITY));
    assign empty          = (count_reg == '0);

    assign bc.act     = act;
    assign bc.key     = req_key;
    assign bc.payload = req_pay;
    assign bc.go      = s_acc && go;

    // row of slot cells; each sees its immediate neighbors, the broadcast request and the shared found flag
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        logic                    left_ge, left_match;
        logic signed [KEY_W-1:0] left_key, right_key;
        logic [PAY_W-1:0]        left_pay, right_pay;

        assign valid[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_ge    = 1'b0;
            assign left_match = 1'b0;
            assign left_key   = req_key;
            assign left_pay   = req_pay;
        end
        else
        begin : g_body
            assign left_ge    = ge[i-1];
            assign left_match = match[i-1];
            assign left_key   = slot_key[i-1];
            assign left_pay   = slot_pay[i-1];
        end

        // last slot has no right neighbor and just holds on a left shift
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key = slot_key[i];
            assign right_pay = slot_pay[i];
        end
        else
        begin : g_next
            assign right_key = slot_key[i+1];
            assign right_pay = slot_pay[i+1];
        end

        skl_cell u_cell (
            .clk       (clk),
            .bc        (bc),
            .valid     (valid[i]),
            .found     (found),
            .left_ge   (left_ge),
            .left_key  (left_key),
            .left_pay  (left_pay),
            .right_key (right_key),
            .right_pay (right_pay),
            .ge        (ge[i]),
            .match     (match[i]),
            .key       (slot_key[i]),
            .pay       (slot_pay[i])
        );

        // slot that supplies the result of this request
        always_comb
        begin
            case (act) inside
                ACT_REMOVE_KEY, ACT_FIND:
                    sel[i] = match[i] && !left_match;
                ACT_REMOVE_FIRST:
                    sel[i] = (i == 0) && !empty;
                ACT_REMOVE_LAST:
                    sel[i] = (count_ext == XW'(i + 1));
                ACT_READ:
                    sel[i] = (pos_ext == XW'(i + 1)) && (pos_ext <= count_ext);
                default:
                    sel[i] = 1'b0;
            endcase
        end

        assign sel_vec[i] = sel[i];
    end

    // equal keys sit together, so at most one slot starts a match run
    always_comb
    begin
        found   = 1'b0;
        res_key = '0;
        res_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found   = found | match[i];
            res_key = res_key | ({KEY_W{sel[i]}} & slot_key[i]);
            res_pay = res_pay | ({PAY_W{sel[i]}} & slot_pay[i]);
        end
    end

    assign hit = |sel_vec;

    // status, list update and new count
    always_comb
    begin
        status_next = ST_MISS;
        go          = 1'b0;
        count_next  = count_reg;
        unique case (act) inside
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    go          = 1'b1;
                    count_next  = count_reg + CW'(1);
                end
            end
            ACT_REMOVE_KEY, ACT_REMOVE_FIRST, ACT_REMOVE_LAST:
            begin
                if (hit)
                begin
                    status_next = ST_OK;
                    go          = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            ACT_READ, ACT_FIND:
            begin
                if (hit)
                begin
                    status_next = ST_OK;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed; entry count carries its low bits only
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            m_tuser_reg <= status_next;
            m_tdata_reg <= {3'b000, count_next_ext[POS_W-1:0], res_pay, res_key};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // count never runs past the number of slots
    `SKL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count overflow")
    // at most one slot drives the result
    `SKL_ASSERT_NOW(a_sel_onehot, clk, rst_n, 1'b1, $onehot0(sel_vec), "multiple result slots")
    // an insert into a list with room grows it by one
    `SKL_ASSERT_NEXT(a_insert_grow, clk, rst_n, s_acc && act == ACT_INSERT && !full,
                     count_reg == $past(count_reg) + CW'(1), "insert did not grow count")
    // a full status only ever answers an insert
    `SKL_ASSERT_NOW(a_full_insert, clk, rst_n, s_acc && status_next == ST_FULL,
                    act == ACT_INSERT, "full status on non-insert")

endmodule
